@@ design/ibb_pkg.sv @@
// Shared types, register indexes, command and status codes for the interval bisection binner.
package ibb_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_LEVELS_DEF   = 8;
    localparam int BIN_CAPACITY_DEF = 16;
    localparam int INDEX_BITS_DEF   = 16;

    // Configuration port geometry
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int LEVEL_W     = 4;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_DOMAIN_LOW  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DOMAIN_HIGH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LEVELS      = 2'd2;

    // Register reset values
    localparam logic signed [31:0] DOMAIN_LOW_RST  = 32'sd0;
    localparam logic signed [31:0] DOMAIN_HIGH_RST = 32'sd65536;
    localparam logic [LEVEL_W-1:0] LEVELS_RST      = 4'd8;

    // Commands
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_FIND   = 1'b1;

    // Result status codes
    localparam logic [2:0] STAT_INSERTED      = 3'd0;
    localparam logic [2:0] STAT_LIST_FULL     = 3'd1;
    localparam logic [2:0] STAT_OUT_OF_DOMAIN = 3'd2;
    localparam logic [2:0] STAT_FOUND_ENTRY   = 3'd3;
    localparam logic [2:0] STAT_FOUND_EMPTY   = 3'd4;
    localparam logic [2:0] STAT_NOT_FOUND     = 3'd5;

    // Input item
    typedef struct packed {
        logic               command;
        logic signed [31:0] point_value;
        logic [15:0]        point_index;
    } in_item_t;

    // Result item
    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  bin_number;
        logic [15:0] stored_index;
        logic [15:0] bin_total;
        logic        last;
    } out_item_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_BISECT,
        S_CNT_RD,
        S_CNT_USE,
        S_IDX_RD,
        S_IDX_USE
    } state_t;

endpackage

@@ design/interval_bisection_binner.sv @@
// Top level: bins points by repeated bisection and keeps per-bin index lists in memories.
//
//  Channel | Ports                                   | Direction
//  --------+-----------------------------------------+----------
//  input   | s_valid, s_ready, s_data (in_item_t)    | in
//  result  | m_valid, m_ready, m_data (out_item_t)   | out
//  config  | cfg_wr_en, cfg_index, cfg_wr_data       | in
//
// One item at a time. Out of domain: the result loads in the check state; insert: check,
// one bisection step per cycle for levels steps, count read, update; find: check,
// bisection, count read, then an index read and a result per stored index. levels is
// the saturated count. After reset a clearing pass writes zero to every bin count;
// s_ready stays low meanwhile, config writes still land.
// A result waits in the output register while m_ready is low; the sequencer stalls there.
module interval_bisection_binner
    import ibb_pkg::*;
#(
    parameter int MAX_LEVELS   = MAX_LEVELS_DEF,
    parameter int BIN_CAPACITY = BIN_CAPACITY_DEF,
    parameter int INDEX_BITS   = INDEX_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_item_t               s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_item_t              m_data,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data
);

    localparam int BIN_W       = (MAX_LEVELS > 0) ? MAX_LEVELS : 1;
    localparam int SLOT_W      = (BIN_CAPACITY > 1) ? $clog2(BIN_CAPACITY) : 1;
    localparam int STORED_W    = $clog2(BIN_CAPACITY + 1);
    localparam int CNT_DEPTH   = 1 << BIN_W;
    localparam int STORE_AW    = BIN_W + SLOT_W;
    localparam int STORE_DEPTH = 1 << STORE_AW;

    // Sequencer
    state_t state_reg, state_next;

    // Configuration registers
    logic signed [31:0] domain_low_reg;
    logic signed [31:0] domain_high_reg;
    logic [LEVEL_W-1:0] levels_reg;

    // Item and bisection registers
    in_item_t           item_reg;
    logic [LEVEL_W-1:0] lv_reg;
    logic signed [31:0] left_reg, right_reg;
    logic [BIN_W-1:0]   bin_reg;
    logic [LEVEL_W-1:0] step_reg;
    logic [SLOT_W-1:0]  k_reg;
    logic [BIN_W-1:0]   clr_addr_reg;

    // Memories
    logic [15:0]           cnt_mem [CNT_DEPTH];
    logic [15:0]           cnt_rdata_reg;
    logic [INDEX_BITS-1:0] idx_mem [STORE_DEPTH];
    logic [INDEX_BITS-1:0] idx_rdata_reg;

    // Output register
    logic      m_valid_reg;
    out_item_t m_data_reg;
    out_item_t out_next;
    logic      load_out;

    // Control
    logic                cnt_we, cnt_re, idx_we, idx_re;
    logic [BIN_W-1:0]    cnt_waddr;
    logic [15:0]         cnt_wdata;
    logic [STORE_AW-1:0] idx_waddr, idx_raddr;

    // Datapath terms
    logic [LEVEL_W-1:0]  lv_sat;
    logic signed [31:0]  point_val;
    logic                out_of_domain;
    logic signed [32:0]  mid_sum, mid_adj;
    logic signed [31:0]  mid;
    logic                go_upper;
    logic                bisect_done;
    logic                has_room;
    logic [15:0]         cnt_inc;
    logic [STORED_W-1:0] stored_num;
    logic [STORED_W-1:0] k_ext;
    logic                last_entry;
    logic                out_free;
    logic                s_xfer;

    assign s_xfer    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign point_val = item_reg.point_value;

    assign lv_sat = (levels_reg > LEVEL_W'(MAX_LEVELS)) ? LEVEL_W'(MAX_LEVELS) : levels_reg;

    assign out_of_domain = (point_val < domain_low_reg) || (point_val > domain_high_reg);

    // Midpoint truncated toward zero: floor of half, plus one for negative odd sums
    assign mid_sum  = {left_reg[31], left_reg} + {right_reg[31], right_reg};
    assign mid_adj  = mid_sum + 33'(mid_sum[32]);
    assign mid      = mid_adj[32:1];
    assign go_upper = !(point_val < mid);

    assign bisect_done = (step_reg + LEVEL_W'(1)) == lv_reg;

    // Count-derived terms
    assign has_room   = cnt_rdata_reg < 16'(BIN_CAPACITY);
    assign cnt_inc    = (cnt_rdata_reg == 16'hFFFF) ? cnt_rdata_reg : cnt_rdata_reg + 16'd1;
    assign stored_num = has_room ? STORED_W'(cnt_rdata_reg) : STORED_W'(BIN_CAPACITY);
    assign k_ext      = STORED_W'(k_reg);
    assign last_entry = (k_ext + STORED_W'(1)) == stored_num;

    // Memory addresses
    assign cnt_waddr = (state_reg == S_CLEAR) ? clr_addr_reg : bin_reg;
    assign cnt_wdata = (state_reg == S_CLEAR) ? 16'd0 : cnt_inc;
    assign idx_waddr = {bin_reg, SLOT_W'(cnt_rdata_reg)};
    assign idx_raddr = {bin_reg, k_reg};

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: begin
                if (clr_addr_reg == {BIN_W{1'b1}}) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid) state_next = S_CHECK;
            end
            S_CHECK: begin
                if (out_of_domain) begin
                    if (out_free) state_next = S_IDLE;
                end else if (lv_reg == '0) begin
                    state_next = S_CNT_RD;
                end else begin
                    state_next = S_BISECT;
                end
            end
            S_BISECT: begin
                if (bisect_done) state_next = S_CNT_RD;
            end
            S_CNT_RD: begin
                state_next = S_CNT_USE;
            end
            S_CNT_USE: begin
                if (item_reg.command == CMD_INSERT || cnt_rdata_reg == 16'd0) begin
                    if (out_free) state_next = S_IDLE;
                end else begin
                    state_next = S_IDX_RD;
                end
            end
            S_IDX_RD: begin
                state_next = S_IDX_USE;
            end
            S_IDX_USE: begin
                if (out_free) state_next = last_entry ? S_IDLE : S_IDX_RD;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_ready               = 1'b0;
        cnt_we                = 1'b0;
        cnt_re                = 1'b0;
        idx_we                = 1'b0;
        idx_re                = 1'b0;
        load_out              = 1'b0;
        out_next.status       = STAT_INSERTED;
        out_next.bin_number   = 8'(bin_reg);
        out_next.stored_index = 16'd0;
        out_next.bin_total    = 16'd0;
        out_next.last         = 1'b1;
        case (state_reg)
            S_CLEAR: begin
                cnt_we = 1'b1;
            end
            S_IDLE: begin
                s_ready = 1'b1;
            end
            S_CHECK: begin
                if (out_of_domain) begin
                    load_out            = out_free;
                    out_next.status     = STAT_OUT_OF_DOMAIN;
                    out_next.bin_number = 8'd0;
                end
            end
            S_CNT_RD: begin
                cnt_re = 1'b1;
            end
            S_CNT_USE: begin
                if (item_reg.command == CMD_INSERT) begin
                    load_out           = out_free;
                    cnt_we             = out_free;
                    idx_we             = out_free && has_room;
                    out_next.status    = has_room ? STAT_INSERTED : STAT_LIST_FULL;
                    out_next.bin_total = cnt_inc;
                end else if (cnt_rdata_reg == 16'd0) begin
                    load_out        = out_free;
                    out_next.status = (lv_reg == '0) ? STAT_FOUND_EMPTY : STAT_NOT_FOUND;
                end
            end
            S_IDX_RD: begin
                idx_re = 1'b1;
            end
            S_IDX_USE: begin
                load_out              = out_free;
                out_next.status       = STAT_FOUND_ENTRY;
                out_next.stored_index = 16'(idx_rdata_reg);
                out_next.bin_total    = cnt_rdata_reg;
                out_next.last         = last_entry;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // State and clearing pass counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR) clr_addr_reg <= clr_addr_reg + BIN_W'(1);
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            domain_low_reg  <= DOMAIN_LOW_RST;
            domain_high_reg <= DOMAIN_HIGH_RST;
            levels_reg      <= LEVELS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_DOMAIN_LOW:  domain_low_reg  <= cfg_wr_data;
                REG_DOMAIN_HIGH: domain_high_reg <= cfg_wr_data;
                REG_LEVELS:      levels_reg      <= cfg_wr_data[LEVEL_W-1:0];
                default:         levels_reg      <= levels_reg;
            endcase
        end
    end

    // Item capture, bisection steps and entry walk
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            item_reg  <= s_data;
            lv_reg    <= lv_sat;
            left_reg  <= domain_low_reg;
            right_reg <= domain_high_reg;
            bin_reg   <= '0;
            step_reg  <= '0;
            k_reg     <= '0;
        end
        if (state_reg == S_BISECT) begin
            if (go_upper) begin
                left_reg <= mid;
                bin_reg  <= BIN_W'({bin_reg, 1'b1});
            end else begin
                right_reg <= mid;
                bin_reg   <= BIN_W'({bin_reg, 1'b0});
            end
            step_reg <= step_reg + LEVEL_W'(1);
        end
        if (state_reg == S_IDX_USE && load_out) k_reg <= k_reg + SLOT_W'(1);
    end

    // Bin count memory
    always_ff @(posedge aclk) begin
        if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
        if (cnt_re) cnt_rdata_reg <= cnt_mem[bin_reg];
    end

    // Index list memory
    always_ff @(posedge aclk) begin
        if (idx_we) idx_mem[idx_waddr] <= INDEX_BITS'(item_reg.point_index);
        if (idx_re) idx_rdata_reg <= idx_mem[idx_raddr];
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) m_data_reg <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    // A held result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten while held");

    // An accepted item always starts with the domain check
    a_accept_check: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> (state_reg == S_CHECK))
        else $error("accepted item did not enter domain check");

    // The entry walk stays inside the stored part of the list
    a_walk_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDX_USE) |-> (k_ext < stored_num))
        else $error("entry walk beyond stored entries");

    // Out-of-domain results carry bin 0, total 0 and the last mark
    a_ood_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == STAT_OUT_OF_DOMAIN) |->
            (m_data.bin_number == 8'd0 && m_data.bin_total == 16'd0 && m_data.last))
        else $error("out-of-domain result fields wrong");

    // A found entry comes from a bin with a nonzero count
    a_found_total: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == STAT_FOUND_ENTRY) |-> (m_data.bin_total != 16'd0))
        else $error("found entry with zero bin total");
`endif

endmodule
